FILE: sv/qau_pkg.sv
// qau_pkg: shared types, constants and helper functions of the quaternion unit
// used by the channel interfaces, the front queue and the back sequencer
`default_nettype none
package qau_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int Q_W           = 32;
   localparam int BLEND_W       = 17;
   localparam int EPS_W         = 16;
   localparam int QUEUE_DEPTH   = 4;
   localparam int STEP_W        = 5;
   localparam int NUM_TMP       = 5;

   localparam logic [2:0] OP_MUL    = 3'd0;
   localparam logic [2:0] OP_ROTATE = 3'd1;
   localparam logic [2:0] OP_INV    = 3'd2;
   localparam logic [2:0] OP_NORM   = 3'd3;
   localparam logic [2:0] OP_NLERP  = 3'd4;
   localparam logic [2:0] OP_DOT    = 3'd5;

   typedef enum logic [2:0] {
      CLS_MUL, CLS_ROT, CLS_INV, CLS_NORM, CLS_NLERP, CLS_DOT, CLS_NONE
   } cls_type;

   typedef enum logic [4:0] {
      SEL_ZERO,
      SEL_A0, SEL_A1, SEL_A2, SEL_A3,
      SEL_B0, SEL_B1, SEL_B2, SEL_B3,
      SEL_T0, SEL_T1, SEL_T2, SEL_T3, SEL_T4,
      SEL_D0, SEL_D1, SEL_D2, SEL_D3,
      SEL_BLEND
   } sel_type;

   typedef enum logic [3:0] {
      DST_R0, DST_R1, DST_R2, DST_R3,
      DST_T0, DST_T1, DST_T2, DST_T3, DST_T4,
      DST_LEN
   } dst_type;

   typedef struct packed {
      sel_type xs;
      sel_type ys;
      sel_type bs;
      logic    neg;
      logic    dbl;
      logic    last;
      dst_type dst;
      logic    fin;
   } ucode_type;

   typedef struct packed {
      cls_type                     cls;
      logic [3:0][Q_W-1:0]         a;
      logic [3:0][Q_W-1:0]         b;
      logic [BLEND_W-1:0]          blend;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [3:0][Q_W-1:0] r;
      logic                deg;
      logic                ovf;
   } res_type;

   typedef struct packed {
      logic           ovf;
      logic [Q_W-1:0] val;
   } sat_type;

   function automatic sat_type sat32(logic signed [63:0] v);
      sat_type s;
      s.ovf = 1'b0;
      s.val = v[Q_W-1:0];
      if (v > 64'sd2147483647) begin
         s.ovf = 1'b1;
         s.val = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         s.ovf = 1'b1;
         s.val = 32'h8000_0000;
      end
      return s;
   endfunction

   // non-final product step of a term
   function automatic ucode_type pp(sel_type xs, sel_type ys, logic neg, logic dbl);
      ucode_type u;
      u.xs   = xs;
      u.ys   = ys;
      u.bs   = SEL_ZERO;
      u.neg  = neg;
      u.dbl  = dbl;
      u.last = 1'b0;
      u.dst  = DST_LEN;
      u.fin  = 1'b0;
      return u;
   endfunction

   // closing step of a term, result goes to dst
   function automatic ucode_type ll(sel_type xs, sel_type ys, logic neg, logic dbl,
                                    dst_type dst, logic fin);
      ucode_type u;
      u      = pp(xs, ys, neg, dbl);
      u.last = 1'b1;
      u.dst  = dst;
      u.fin  = fin;
      return u;
   endfunction

   // product schedule of every operation class
   function automatic ucode_type ucode(cls_type cls, logic [STEP_W-1:0] step);
      ucode_type u;
      u     = pp(SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
      u.fin = 1'b1;
      case (cls)
         CLS_MUL: begin
            case (int'(step))
               0:  u = pp(SEL_B0, SEL_A3, 1'b0, 1'b0);
               1:  u = pp(SEL_B1, SEL_A2, 1'b0, 1'b0);
               2:  u = pp(SEL_B2, SEL_A1, 1'b1, 1'b0);
               3:  u = ll(SEL_B3, SEL_A0, 1'b0, 1'b0, DST_R0, 1'b0);
               4:  u = pp(SEL_B0, SEL_A2, 1'b1, 1'b0);
               5:  u = pp(SEL_B1, SEL_A3, 1'b0, 1'b0);
               6:  u = pp(SEL_B2, SEL_A0, 1'b0, 1'b0);
               7:  u = ll(SEL_B3, SEL_A1, 1'b0, 1'b0, DST_R1, 1'b0);
               8:  u = pp(SEL_B0, SEL_A1, 1'b0, 1'b0);
               9:  u = pp(SEL_B1, SEL_A0, 1'b1, 1'b0);
               10: u = pp(SEL_B2, SEL_A3, 1'b0, 1'b0);
               11: u = ll(SEL_B3, SEL_A2, 1'b0, 1'b0, DST_R2, 1'b0);
               12: u = pp(SEL_B0, SEL_A0, 1'b1, 1'b0);
               13: u = pp(SEL_B1, SEL_A1, 1'b1, 1'b0);
               14: u = pp(SEL_B2, SEL_A2, 1'b1, 1'b0);
               15: u = ll(SEL_B3, SEL_A3, 1'b0, 1'b0, DST_R3, 1'b1);
               default: ;
            endcase
         end
         CLS_ROT: begin
            case (int'(step))
               0:  u = pp(SEL_A0, SEL_B0, 1'b0, 1'b0);
               1:  u = pp(SEL_A1, SEL_B1, 1'b0, 1'b0);
               2:  u = ll(SEL_A2, SEL_B2, 1'b0, 1'b0, DST_T0, 1'b0);
               3:  u = pp(SEL_A3, SEL_A3, 1'b0, 1'b0);
               4:  u = pp(SEL_A0, SEL_A0, 1'b1, 1'b0);
               5:  u = pp(SEL_A1, SEL_A1, 1'b1, 1'b0);
               6:  u = ll(SEL_A2, SEL_A2, 1'b1, 1'b0, DST_T1, 1'b0);
               7:  u = pp(SEL_A1, SEL_B2, 1'b0, 1'b0);
               8:  u = ll(SEL_A2, SEL_B1, 1'b1, 1'b0, DST_T2, 1'b0);
               9:  u = pp(SEL_A2, SEL_B0, 1'b0, 1'b0);
               10: u = ll(SEL_A0, SEL_B2, 1'b1, 1'b0, DST_T3, 1'b0);
               11: u = pp(SEL_A0, SEL_B1, 1'b0, 1'b0);
               12: u = ll(SEL_A1, SEL_B0, 1'b1, 1'b0, DST_T4, 1'b0);
               13: u = pp(SEL_A0, SEL_T0, 1'b0, 1'b1);
               14: u = pp(SEL_B0, SEL_T1, 1'b0, 1'b0);
               15: u = ll(SEL_A3, SEL_T2, 1'b0, 1'b1, DST_R0, 1'b0);
               16: u = pp(SEL_A1, SEL_T0, 1'b0, 1'b1);
               17: u = pp(SEL_B1, SEL_T1, 1'b0, 1'b0);
               18: u = ll(SEL_A3, SEL_T3, 1'b0, 1'b1, DST_R1, 1'b0);
               19: u = pp(SEL_A2, SEL_T0, 1'b0, 1'b1);
               20: u = pp(SEL_B2, SEL_T1, 1'b0, 1'b0);
               21: u = ll(SEL_A3, SEL_T4, 1'b0, 1'b1, DST_R2, 1'b1);
               default: ;
            endcase
         end
         CLS_INV, CLS_NORM: begin
            case (int'(step))
               0: u = pp(SEL_A0, SEL_A0, 1'b0, 1'b0);
               1: u = pp(SEL_A1, SEL_A1, 1'b0, 1'b0);
               2: u = pp(SEL_A2, SEL_A2, 1'b0, 1'b0);
               3: u = ll(SEL_A3, SEL_A3, 1'b0, 1'b0, DST_LEN, 1'b1);
               default: ;
            endcase
         end
         CLS_NLERP: begin
            case (int'(step))
               0: begin
                  u    = ll(SEL_D0, SEL_BLEND, 1'b0, 1'b0, DST_T0, 1'b0);
                  u.bs = SEL_A0;
               end
               1: begin
                  u    = ll(SEL_D1, SEL_BLEND, 1'b0, 1'b0, DST_T1, 1'b0);
                  u.bs = SEL_A1;
               end
               2: begin
                  u    = ll(SEL_D2, SEL_BLEND, 1'b0, 1'b0, DST_T2, 1'b0);
                  u.bs = SEL_A2;
               end
               3: begin
                  u    = ll(SEL_D3, SEL_BLEND, 1'b0, 1'b0, DST_T3, 1'b0);
                  u.bs = SEL_A3;
               end
               4: u = pp(SEL_T0, SEL_T0, 1'b0, 1'b0);
               5: u = pp(SEL_T1, SEL_T1, 1'b0, 1'b0);
               6: u = pp(SEL_T2, SEL_T2, 1'b0, 1'b0);
               7: u = ll(SEL_T3, SEL_T3, 1'b0, 1'b0, DST_LEN, 1'b1);
               default: ;
            endcase
         end
         CLS_DOT: begin
            case (int'(step))
               0: u = pp(SEL_A0, SEL_B0, 1'b0, 1'b0);
               1: u = pp(SEL_A1, SEL_B1, 1'b0, 1'b0);
               2: u = pp(SEL_A2, SEL_B2, 1'b0, 1'b0);
               3: u = ll(SEL_A3, SEL_B3, 1'b0, 1'b0, DST_R3, 1'b1);
               default: ;
            endcase
         end
         default: ;
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

FILE: sv/qau_if.sv
// qau_req_if / qau_rsp_if: valid-ready channels of the quaternion unit
// widths come from qau_pkg
`default_nettype none
interface qau_req_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    req_type;
   logic signed [qau_pkg::Q_W-1:0] a_x;
   logic signed [qau_pkg::Q_W-1:0] a_y;
   logic signed [qau_pkg::Q_W-1:0] a_z;
   logic signed [qau_pkg::Q_W-1:0] a_w;
   logic signed [qau_pkg::Q_W-1:0] b_x;
   logic signed [qau_pkg::Q_W-1:0] b_y;
   logic signed [qau_pkg::Q_W-1:0] b_z;
   logic signed [qau_pkg::Q_W-1:0] b_w;
   logic [qau_pkg::BLEND_W-1:0]    blend;

   modport source (output valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                   input ready);
   modport sink   (input valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                   output ready);
endinterface

interface qau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [qau_pkg::Q_W-1:0] r_x;
   logic signed [qau_pkg::Q_W-1:0] r_y;
   logic signed [qau_pkg::Q_W-1:0] r_z;
   logic signed [qau_pkg::Q_W-1:0] r_w;
   logic                          degenerate;
   logic                          overflow;

   modport source (output valid, r_x, r_y, r_z, r_w, degenerate, overflow, input ready);
   modport sink   (input valid, r_x, r_y, r_z, r_w, degenerate, overflow, output ready);
endinterface
`default_nettype wire

FILE: sv/qau_front.sv
// qau_front: takes request transfers, classifies the operation code and queues them
// depends on qau_pkg and qau_req_if
`default_nettype none
module qau_front (
   input  wire logic          clock,
   input  wire logic          reset,
   qau_req_if.sink            req,
   input  wire logic          pop,
   output qau_pkg::entry_type head,
   output qau_pkg::qstat_type stat
);
   localparam int DEPTH = qau_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   qau_pkg::entry_type q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push;
   qau_pkg::entry_type item;

   assign req.ready  = (cnt_ff != CNT_W'(DEPTH));
   assign push       = req.valid && req.ready;
   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head       = q_ff[rd_ff];

   always_comb begin
      case (req.req_type)
         qau_pkg::OP_MUL:    item.cls = qau_pkg::CLS_MUL;
         qau_pkg::OP_ROTATE: item.cls = qau_pkg::CLS_ROT;
         qau_pkg::OP_INV:    item.cls = qau_pkg::CLS_INV;
         qau_pkg::OP_NORM:   item.cls = qau_pkg::CLS_NORM;
         qau_pkg::OP_NLERP:  item.cls = qau_pkg::CLS_NLERP;
         qau_pkg::OP_DOT:    item.cls = qau_pkg::CLS_DOT;
         default:            item.cls = qau_pkg::CLS_NONE;
      endcase
      item.a     = {req.a_w, req.a_z, req.a_y, req.a_x};
      item.b     = {req.b_w, req.b_z, req.b_y, req.b_x};
      item.blend = req.blend;
   end

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= item;
      end
   end
endmodule
`default_nettype wire

FILE: sv/qau_div.sv
// qau_div: unsigned 64 by 64 restoring divider, one quotient bit per cycle
// standalone, no package use
`default_nettype none
module qau_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in, dvd_ff, dvd_in, dvs_ff, dvs_in, q_ff, q_in;
   logic [64:0] trial;

   assign done     = done_ff;
   assign quotient = q_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      trial   = {rem_ff, dvd_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 64'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end
endmodule
`default_nettype wire

FILE: sv/qau_sqrt.sv
// qau_sqrt: 64-bit integer square root, two radicand bits per cycle
// standalone, no package use
`default_nettype none
module qau_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic [31:0]      root
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in, trial;

   assign done = done_ff;
   assign root = res_ff[31:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = radicand;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end
endmodule
`default_nettype wire

FILE: sv/qau_back.sv
// qau_back: sequencer that runs one queued request on a shared multiplier,
// the divider and the square root unit, with an output register on the result side
// depends on qau_pkg, qau_rsp_if, qau_div and qau_sqrt
`default_nettype none
module qau_back #(
   parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [qau_pkg::EPS_W-1:0]  eps,
   input  wire qau_pkg::entry_type         head,
   input  wire logic                       empty,
   output logic                            pop,
   qau_rsp_if.source                       rsp
);
   localparam logic signed [67:0] HALF    = 68'sd1 <<< (FRAC_BITS - 1);
   localparam logic [63:0]        LEN_CAP = {64{1'b1}} >> FRAC_BITS;
   localparam logic [31:0]        ONE     = 32'(64'd1 << FRAC_BITS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PROD, ST_DRAIN, ST_CHECK, ST_SQRT, ST_DIV, ST_OUT
   } state_type;

   state_type                     state_ff, state_in;
   qau_pkg::entry_type            ent_ff, ent_in;
   logic [qau_pkg::STEP_W-1:0]    step_ff, step_in;
   logic signed [63:0]            acc_ff, acc_in;
   logic signed [67:0]            prod_ff, prod_in;
   qau_pkg::ucode_type            pctl_ff, pctl_in;
   logic                          pvld_ff, pvld_in;
   logic [31:0]                   base_ff, base_in;
   logic [qau_pkg::NUM_TMP-1:0][31:0] tmp_ff, tmp_in;
   logic [3:0][31:0]              r_ff, r_in;
   logic [63:0]                   len_ff, len_in;
   logic [31:0]                   root_ff, root_in;
   logic [1:0]                    comp_ff, comp_in;
   logic                          deg_ff, deg_in, ovf_ff, ovf_in;
   logic                          div_go_ff, div_go_in, sqrt_go_ff, sqrt_go_in;
   logic                          rv_ff, rv_in;
   qau_pkg::res_type              rdata_ff, rdata_in;

   qau_pkg::ucode_type uc;
   logic signed [33:0] opx, opy, opb;
   logic signed [67:0] rnd_wide;
   logic signed [63:0] term, sum;
   qau_pkg::sat_type   sat;
   logic               too_small;
   logic [63:0]        sqrt_x;
   logic               sqrt_start, sqrt_done;
   logic [31:0]        sqrt_root;
   logic [31:0]        src;
   logic [32:0]        mag;
   logic               div_neg;
   logic [63:0]        div_dvs, div_dvd, div_q;
   logic               div_start, div_done;
   logic [31:0]        div_val;
   logic               div_ovf;

   function automatic logic signed [33:0] sx(logic [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   function automatic logic signed [33:0] pick(qau_pkg::sel_type s, qau_pkg::entry_type e,
                                               logic [qau_pkg::NUM_TMP-1:0][31:0] t);
      case (s)
         qau_pkg::SEL_A0:    return sx(e.a[0]);
         qau_pkg::SEL_A1:    return sx(e.a[1]);
         qau_pkg::SEL_A2:    return sx(e.a[2]);
         qau_pkg::SEL_A3:    return sx(e.a[3]);
         qau_pkg::SEL_B0:    return sx(e.b[0]);
         qau_pkg::SEL_B1:    return sx(e.b[1]);
         qau_pkg::SEL_B2:    return sx(e.b[2]);
         qau_pkg::SEL_B3:    return sx(e.b[3]);
         qau_pkg::SEL_T0:    return sx(t[0]);
         qau_pkg::SEL_T1:    return sx(t[1]);
         qau_pkg::SEL_T2:    return sx(t[2]);
         qau_pkg::SEL_T3:    return sx(t[3]);
         qau_pkg::SEL_T4:    return sx(t[4]);
         qau_pkg::SEL_D0:    return sx(e.b[0]) - sx(e.a[0]);
         qau_pkg::SEL_D1:    return sx(e.b[1]) - sx(e.a[1]);
         qau_pkg::SEL_D2:    return sx(e.b[2]) - sx(e.a[2]);
         qau_pkg::SEL_D3:    return sx(e.b[3]) - sx(e.a[3]);
         qau_pkg::SEL_BLEND: return $signed({17'd0, e.blend});
         default:            return '0;
      endcase
   endfunction

   assign uc  = qau_pkg::ucode(ent_ff.cls, step_ff);
   assign opx = pick(uc.xs, ent_ff, tmp_ff);
   assign opy = pick(uc.ys, ent_ff, tmp_ff);
   assign opb = pick(uc.bs, ent_ff, tmp_ff);

   // rounded product, ties toward plus infinity
   assign rnd_wide = (prod_ff + HALF) >>> FRAC_BITS;

   always_comb begin
      term = $signed(rnd_wide[63:0]);
      if (pctl_ff.dbl) begin
         term = term <<< 1;
      end
      if (pctl_ff.neg) begin
         term = -term;
      end
      sum = acc_ff + term + $signed({{32{base_ff[31]}}, base_ff});
      sat = qau_pkg::sat32(sum);
   end

   assign too_small = (len_ff == 64'd0) || (len_ff < 64'(eps));
   assign sqrt_x    = (len_ff > LEN_CAP ? LEN_CAP : len_ff) << FRAC_BITS;

   // divider operands for component comp_ff
   always_comb begin
      src     = (ent_ff.cls == qau_pkg::CLS_NLERP) ? tmp_ff[{1'b0, comp_ff}]
                                                    : ent_ff.a[comp_ff];
      mag     = src[31] ? 33'd0 - {1'b1, src} : {1'b0, src};
      div_neg = (ent_ff.cls == qau_pkg::CLS_INV && comp_ff != 2'd3)
                ? (!src[31] && src != 32'd0) : src[31];
      div_dvs = (ent_ff.cls == qau_pkg::CLS_INV) ? len_ff : {32'd0, root_ff};
      div_dvd = ({31'd0, mag} << FRAC_BITS) + (div_dvs >> 1);
      div_ovf = 1'b0;
      if (div_neg) begin
         div_val = 32'(64'd0 - div_q);
         if (div_q > 64'd2147483648) begin
            div_ovf = 1'b1;
            div_val = 32'h8000_0000;
         end
      end else begin
         div_val = div_q[31:0];
         if (div_q > 64'd2147483647) begin
            div_ovf = 1'b1;
            div_val = 32'h7FFF_FFFF;
         end
      end
   end

   qau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   qau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_x),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      state_in   = state_ff;
      ent_in     = ent_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      prod_in    = opx * opy;
      pctl_in    = uc;
      pvld_in    = 1'b0;
      base_in    = opb[31:0];
      tmp_in     = tmp_ff;
      r_in       = r_ff;
      len_in     = len_ff;
      root_in    = root_ff;
      comp_in    = comp_ff;
      deg_in     = deg_ff;
      ovf_in     = ovf_ff;
      div_go_in  = div_go_ff;
      sqrt_go_in = sqrt_go_ff;
      rv_in      = rv_ff;
      rdata_in   = rdata_ff;
      pop        = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;

      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               ent_in  = head;
               step_in = '0;
               acc_in  = '0;
               r_in    = '0;
               deg_in  = 1'b0;
               ovf_in  = 1'b0;
               state_in = (head.cls == qau_pkg::CLS_NONE) ? ST_OUT : ST_PROD;
            end
         end
         ST_PROD: begin
            pvld_in = 1'b1;
            step_in = step_ff + qau_pkg::STEP_W'(1);
            if (uc.fin) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (ent_ff.cls == qau_pkg::CLS_MUL || ent_ff.cls == qau_pkg::CLS_ROT ||
                ent_ff.cls == qau_pkg::CLS_DOT) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            comp_in = '0;
            if (too_small) begin
               r_in     = '0;
               r_in[3]  = ONE;
               deg_in   = 1'b1;
               state_in = ST_OUT;
            end else if (ent_ff.cls == qau_pkg::CLS_INV) begin
               div_go_in = 1'b1;
               state_in  = ST_DIV;
            end else begin
               sqrt_go_in = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_go_ff) begin
               sqrt_start = 1'b1;
               sqrt_go_in = 1'b0;
            end
            if (sqrt_done) begin
               root_in   = sqrt_root;
               div_go_in = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_go_ff) begin
               div_start = 1'b1;
               div_go_in = 1'b0;
            end
            if (div_done) begin
               r_in[comp_ff] = div_val;
               ovf_in        = ovf_ff | div_ovf;
               if (comp_ff == 2'd3) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in   = comp_ff + 2'd1;
                  div_go_in = 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in        = 1'b1;
               rdata_in.r   = r_ff;
               rdata_in.deg = deg_ff;
               rdata_in.ovf = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // retire the registered product into the accumulator, or into its destination on a term's last step
      if (pvld_ff) begin
         if (pctl_ff.last) begin
            acc_in = '0;
            case (pctl_ff.dst)
               qau_pkg::DST_R0: r_in[0]   = sat.val;
               qau_pkg::DST_R1: r_in[1]   = sat.val;
               qau_pkg::DST_R2: r_in[2]   = sat.val;
               qau_pkg::DST_R3: r_in[3]   = sat.val;
               qau_pkg::DST_T0: tmp_in[0] = sat.val;
               qau_pkg::DST_T1: tmp_in[1] = sat.val;
               qau_pkg::DST_T2: tmp_in[2] = sat.val;
               qau_pkg::DST_T3: tmp_in[3] = sat.val;
               qau_pkg::DST_T4: tmp_in[4] = sat.val;
               default:         len_in    = sum;
            endcase
            if (pctl_ff.dst != qau_pkg::DST_LEN) begin
               ovf_in = ovf_in | sat.ovf;
            end
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pvld_ff    <= 1'b0;
         div_go_ff  <= 1'b0;
         sqrt_go_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pvld_ff    <= pvld_in;
         div_go_ff  <= div_go_in;
         sqrt_go_ff <= sqrt_go_in;
         rv_ff      <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      step_ff  <= step_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      pctl_ff  <= pctl_in;
      base_ff  <= base_in;
      tmp_ff   <= tmp_in;
      r_ff     <= r_in;
      len_ff   <= len_in;
      root_ff  <= root_in;
      comp_ff  <= comp_in;
      deg_ff   <= deg_in;
      ovf_ff   <= ovf_in;
      rdata_ff <= rdata_in;
   end

   assign rsp.valid      = rv_ff;
   assign rsp.r_x        = rdata_ff.r[0];
   assign rsp.r_y        = rdata_ff.r[1];
   assign rsp.r_z        = rdata_ff.r[2];
   assign rsp.r_w        = rdata_ff.r[3];
   assign rsp.degenerate = rdata_ff.deg;
   assign rsp.overflow   = rdata_ff.ovf;
endmodule
`default_nettype wire

FILE: sv/quaternion_arithmetic_unit_core.sv
// quaternion_arithmetic_unit_core: top level of the fixed-point quaternion unit
// depends on qau_pkg, qau_if, qau_front and qau_back
//
// usage:
//   req_ch carries one request per transfer (operation code, quaternions a and b,
//   blend); rsp_ch returns exactly one result per request, in request order.
//   csr_we / csr_wdata write the degenerate-length threshold (reset value 1).
// throughput and sequencing:
//   the front takes a transfer in any cycle in which its 4-entry queue has room,
//   so short bursts enter back to back. the back runs one request at a time on a
//   single shared multiplier, one product per cycle; unknown codes go straight to
//   the output. inverse then runs four divisions on the divider; normalize and
//   nlerp run a square root before the four divisions. degenerate inputs finish
//   right after the length check. sustained rate is set by the back sequencer.
// reset: synchronous, empties the queue and drops any pending result.
// stall: a finished result waits in the output register while the back already
//   starts the next queued request; the front keeps filling the queue.
`default_nettype none
module quaternion_arithmetic_unit_core #(
   parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   qau_req_if.sink                        req_ch,
   qau_rsp_if.source                      rsp_ch,
   input  wire logic                      csr_we,
   input  wire logic [qau_pkg::EPS_W-1:0] csr_wdata
);
   localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

   logic [qau_pkg::EPS_W-1:0] eps_ff, eps_in;
   qau_pkg::entry_type        head;
   qau_pkg::qstat_type        fstat;
   logic                      pop;

   assign eps_in = csr_we ? csr_wdata : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= qau_pkg::EPS_W'(1);
      end else begin
         eps_ff <= eps_in;
      end
   end

   qau_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .pop   (pop),
      .head  (head),
      .stat  (fstat)
   );

   qau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .eps   (eps_ff),
      .head  (head),
      .empty (fstat.empty),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

   // a degenerate result is always the identity
   a_deg_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |->
         rsp_ch.r_x == 0 && rsp_ch.r_y == 0 && rsp_ch.r_z == 0 && rsp_ch.r_w == ONE)
      else $error("degenerate result is not the identity");

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   // the queue never pops while empty and never takes a transfer while full
   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      !(pop && fstat.empty) && !(fstat.full && req_ch.ready))
      else $error("queue overrun or underrun");
endmodule
`default_nettype wire
